[rtl/cns_pkg.sv]
// ============================================================================
// cns_pkg - shared types and constants for the colored noise shaper
// Widths, fixed-point coefficients (Q.24) and the tag that travels with each
// product through the shared multiplier.
// ============================================================================
`default_nettype none

package cns_pkg;

  // Sample and datapath widths
  localparam int SAMPLE_BITS = 16;
  localparam int W_W         = 25;                 // white sample widened to Q.24
  localparam int W_PAD       = W_W - SAMPLE_BITS;
  localparam int A_W         = 36;                 // multiplier operand A
  localparam int B_W         = 25;                 // multiplier operand B
  localparam int P_W         = A_W + B_W;          // full product
  localparam int OUT_W       = 19;
  localparam int LEVEL_W     = 16;
  localparam int NPOLE       = 6;
  localparam int IDX_W       = 3;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 16'd32768;

  // Configuration register indexes
  localparam logic CFG_MODE  = 1'b0;
  localparam logic CFG_LEVEL = 1'b1;

  // Noise modes
  localparam logic [1:0] MODE_WHITE = 2'd0;
  localparam logic [1:0] MODE_PINK  = 2'd1;
  localparam logic [1:0] MODE_BROWN = 2'd2;
  localparam logic [1:0] MODE_BAD   = 2'd3;

  // Post-multiply actions
  localparam logic [3:0] OP_NONE      = 4'd0;
  localparam logic [3:0] OP_PIN       = 4'd1;
  localparam logic [3:0] OP_POLE      = 4'd2;
  localparam logic [3:0] OP_DIRECT    = 4'd3;
  localparam logic [3:0] OP_DELAY     = 4'd4;
  localparam logic [3:0] OP_PINK_OUT  = 4'd5;
  localparam logic [3:0] OP_BROWN_IN  = 4'd6;
  localparam logic [3:0] OP_BROWN_INV = 4'd7;
  localparam logic [3:0] OP_OUT24     = 4'd8;
  localparam logic [3:0] OP_OUT25     = 4'd9;

  // Pink filter coefficients, Q.24
  localparam logic signed [B_W-1:0] POLE_GAIN [NPOLE] = '{
    25'sd16758090, 25'sd16665144, 25'sd16257122,
    25'sd14537458, 25'sd9227469,  -25'sd12777528
  };
  localparam logic signed [B_W-1:0] POLE_IN [NPOLE] = '{
    25'sd931436,  25'sd1259565, 25'sd2581208,
    25'sd5209084, 25'sd8941454, -25'sd283501
  };
  localparam logic signed [B_W-1:0] K_DIRECT    = 25'sd8995943;
  localparam logic signed [B_W-1:0] K_PINK_OUT  = 25'sd1845494;
  localparam logic signed [B_W-1:0] K_DELAY     = 25'sd1944916;
  localparam logic signed [B_W-1:0] K_BROWN_IN  = 25'sd335544;
  localparam logic signed [B_W-1:0] K_BROWN_INV = 25'sd16448251;

  // Tag carried alongside each product
  typedef struct packed {
    logic             valid;
    logic [3:0]       op;
    logic [IDX_W-1:0] idx;
  } cns_tag_t;

endpackage

`default_nettype wire

[rtl/cns_mul.sv]
// ============================================================================
// cns_mul - shared signed multiplier
// One registered signed multiply per cycle; the action tag rides along so
// the sequencer knows what to do with the product in the next cycle.
// ============================================================================
`default_nettype none

module cns_mul (
  input  wire                               clk,
  input  wire                               rst,
  input  wire logic signed [cns_pkg::A_W-1:0] a,
  input  wire logic signed [cns_pkg::B_W-1:0] b,
  input  wire cns_pkg::cns_tag_t            tag_in,
  output logic signed [cns_pkg::P_W-1:0]    prod,
  output cns_pkg::cns_tag_t                 tag_out
);

  // Register the product; payload needs no reset
  always_ff @(posedge clk) begin
    prod <= (cns_pkg::P_W)'(a) * (cns_pkg::P_W)'(b);
  end

  // Advance the tag; clear its valid bit on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out <= '0;
    end else begin
      tag_out <= tag_in;
    end
  end

endmodule

`default_nettype wire

[rtl/colored_noise_shaper.sv]
// ============================================================================
// colored_noise_shaper - white / pink / brown noise shaper with output level
// A small sequencer drives one shared multiplier through the filter steps
// of the selected mode and saturates the scaled result to Q4.15.
// ============================================================================
// The final multiply waits while the previous result still sits in the output
// register. A new sample is taken only once the result of the current one has
// landed in the output register, since the single multiplier works through
// the dependent filter steps of one sample at a time.
// Synchronous reset clears mode, level, all filter state and the handshakes.
`default_nettype none

module colored_noise_shaper (
  input  wire                                    clk,
  input  wire                                    rst,
  input  wire                                    in_valid,
  output logic                                   in_stall,
  input  wire logic signed [cns_pkg::SAMPLE_BITS-1:0] white_sample,
  output logic                                   out_valid,
  input  wire                                    out_stall,
  output logic signed [cns_pkg::OUT_W-1:0]       noise_sample,
  input  wire                                    cfg_valid,
  output logic                                   cfg_ready,
  input  wire                                    cfg_index,
  input  wire [cns_pkg::LEVEL_W-1:0]             cfg_data
);

  // Operand A sources
  localparam logic [2:0] A_WHITE  = 3'd0;
  localparam logic [2:0] A_POLE   = 3'd1;
  localparam logic [2:0] A_SUM    = 3'd2;
  localparam logic [2:0] A_TMP    = 3'd3;
  localparam logic [2:0] A_BROWN7 = 3'd4;

  localparam logic [4:0] STEP_DIRECT   = 5'd12;
  localparam logic [4:0] STEP_DELAY    = 5'd13;
  localparam logic [4:0] STEP_PINK_OUT = 5'd14;
  localparam logic [4:0] STEP_PINK_FIN = 5'd16;
  localparam logic [4:0] STEP_BRN_INV  = 5'd2;
  localparam logic [4:0] STEP_BRN_FIN  = 5'd4;

  typedef struct packed {
    logic [2:0]                       a_sel;
    logic signed [cns_pkg::B_W-1:0]   b;
    cns_pkg::cns_tag_t                tag;
  } cns_issue_t;

  // Configuration
  logic [1:0]                    mode;
  logic [cns_pkg::LEVEL_W-1:0]   level;

  // Control
  logic       busy;
  logic       run;
  logic [4:0] step;

  // Working and filter state
  logic signed [cns_pkg::W_W-1:0] w;
  logic signed [cns_pkg::A_W-1:0] sum;
  logic signed [cns_pkg::A_W-1:0] tmp;
  logic signed [31:0]             pole [cns_pkg::NPOLE];
  logic signed [23:0]             delay;
  logic signed [31:0]             brown;

  // Multiplier interface
  cns_issue_t                      iss;
  logic signed [cns_pkg::A_W-1:0]  mul_a;
  cns_pkg::cns_tag_t               mul_tag;
  logic signed [cns_pkg::P_W-1:0]  prod;
  cns_pkg::cns_tag_t               prod_tag;

  logic signed [cns_pkg::A_W-1:0]  brown_ext;
  logic signed [cns_pkg::A_W-1:0]  brown7;
  logic signed [cns_pkg::P_W-1:0]  prod_h24;
  logic signed [cns_pkg::P_W-1:0]  prod_h25;
  logic signed [36:0]              r24;
  logic signed [35:0]              r25;
  logic signed [37:0]              pole_sum;
  logic signed [31:0]              pole_new;
  logic signed [37:0]              out_full;

  logic in_xfer;
  logic out_xfer;
  logic cfg_xfer;
  logic is_final;
  logic hold;

  function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
    if (v > 38'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -38'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  function automatic logic signed [cns_pkg::OUT_W-1:0] sat_out(input logic signed [37:0] v);
    if (v > 38'sd262143) begin
      return 19'sh3ffff;
    end else if (v < -38'sd262144) begin
      return 19'sh40000;
    end else begin
      return v[cns_pkg::OUT_W-1:0];
    end
  endfunction

  // Schedule of the shared multiplier for each mode and step
  function automatic cns_issue_t decode(input logic [1:0] m, input logic [4:0] s,
                                        input logic [cns_pkg::LEVEL_W-1:0] lvl);
    cns_issue_t r;
    logic [cns_pkg::IDX_W-1:0] i;
    r = '0;
    i = s[3:1];
    case (m)
      cns_pkg::MODE_PINK: begin
        if (s < STEP_DIRECT) begin
          r.tag.valid = 1'b1;
          r.tag.idx   = i;
          if (s[0] == 1'b0) begin
            r.a_sel  = A_WHITE;
            r.b      = cns_pkg::POLE_IN[i];
            r.tag.op = cns_pkg::OP_PIN;
          end else begin
            r.a_sel  = A_POLE;
            r.b      = cns_pkg::POLE_GAIN[i];
            r.tag.op = cns_pkg::OP_POLE;
          end
        end else if (s == STEP_DIRECT) begin
          r.a_sel = A_WHITE; r.b = cns_pkg::K_DIRECT;
          r.tag.valid = 1'b1; r.tag.op = cns_pkg::OP_DIRECT;
        end else if (s == STEP_DELAY) begin
          r.a_sel = A_WHITE; r.b = cns_pkg::K_DELAY;
          r.tag.valid = 1'b1; r.tag.op = cns_pkg::OP_DELAY;
        end else if (s == STEP_PINK_OUT) begin
          r.a_sel = A_SUM; r.b = cns_pkg::K_PINK_OUT;
          r.tag.valid = 1'b1; r.tag.op = cns_pkg::OP_PINK_OUT;
        end else if (s == STEP_PINK_FIN) begin
          r.a_sel = A_TMP; r.b = {9'b0, lvl};
          r.tag.valid = 1'b1; r.tag.op = cns_pkg::OP_OUT24;
        end
      end
      cns_pkg::MODE_BROWN: begin
        if (s == 5'd0) begin
          r.a_sel = A_WHITE; r.b = cns_pkg::K_BROWN_IN;
          r.tag.valid = 1'b1; r.tag.op = cns_pkg::OP_BROWN_IN;
        end else if (s == STEP_BRN_INV) begin
          r.a_sel = A_TMP; r.b = cns_pkg::K_BROWN_INV;
          r.tag.valid = 1'b1; r.tag.op = cns_pkg::OP_BROWN_INV;
        end else if (s == STEP_BRN_FIN) begin
          r.a_sel = A_BROWN7; r.b = {9'b0, lvl};
          r.tag.valid = 1'b1; r.tag.op = cns_pkg::OP_OUT25;
        end
      end
      default: begin
        r.a_sel = A_WHITE; r.b = {9'b0, lvl};
        r.tag.valid = 1'b1; r.tag.op = cns_pkg::OP_OUT24;
      end
    endcase
    return r;
  endfunction

  // Handshakes
  assign in_stall  = busy;
  assign cfg_ready = ~busy;
  assign in_xfer   = in_valid & ~in_stall;
  assign out_xfer  = out_valid & ~out_stall;
  assign cfg_xfer  = cfg_valid & cfg_ready;

  // Issue control: hold the final multiply until the output register is free
  assign iss      = decode(mode, step, level);
  assign is_final = (iss.tag.op == cns_pkg::OP_OUT24) || (iss.tag.op == cns_pkg::OP_OUT25);
  assign hold     = is_final & out_valid;

  // Operand A select
  assign brown_ext = {{(cns_pkg::A_W-32){brown[31]}}, brown};
  assign brown7    = (brown_ext <<< 3) - brown_ext;

  always_comb begin
    case (iss.a_sel)
      A_WHITE:  mul_a = {{(cns_pkg::A_W-cns_pkg::W_W){w[cns_pkg::W_W-1]}}, w};
      A_POLE:   mul_a = {{(cns_pkg::A_W-32){pole[iss.tag.idx][31]}}, pole[iss.tag.idx]};
      A_SUM:    mul_a = sum;
      A_TMP:    mul_a = tmp;
      A_BROWN7: mul_a = brown7;
      default:  mul_a = '0;
    endcase
  end

  always_comb begin
    mul_tag       = iss.tag;
    mul_tag.valid = iss.tag.valid & run & ~hold;
  end

  cns_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .a       (mul_a),
    .b       (iss.b),
    .tag_in  (mul_tag),
    .prod    (prod),
    .tag_out (prod_tag)
  );

  // Round half up back to Q.24, and to Q.15 for the two output scalings
  assign prod_h24 = prod + (cns_pkg::P_W)'(64'sd8388608);
  assign prod_h25 = prod + (cns_pkg::P_W)'(64'sd16777216);
  assign r24      = prod_h24[cns_pkg::P_W-1:24];
  assign r25      = prod_h25[cns_pkg::P_W-1:25];

  assign pole_sum = {{2{tmp[cns_pkg::A_W-1]}}, tmp} + {r24[36], r24};
  assign pole_new = sat32(pole_sum);
  assign out_full = (prod_tag.op == cns_pkg::OP_OUT25) ? {{2{r25[35]}}, r25}
                                                       : {r24[36], r24};

  // Configuration registers: ignore a mode of 3, clamp the level
  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= cns_pkg::MODE_WHITE;
      level <= '0;
    end else if (cfg_xfer) begin
      if (cfg_index == cns_pkg::CFG_MODE) begin
        if (cfg_data[1:0] != cns_pkg::MODE_BAD) begin
          mode <= cfg_data[1:0];
        end
      end else begin
        level <= (cfg_data > cns_pkg::LEVEL_MAX) ? cns_pkg::LEVEL_MAX : cfg_data;
      end
    end
  end

  // Sequencer: start on input transfer, step through the schedule
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      run  <= 1'b0;
      step <= '0;
    end else begin
      if (in_xfer) begin
        busy <= 1'b1;
        run  <= 1'b1;
        step <= '0;
      end else if (run && !hold) begin
        step <= step + 5'd1;
        if (is_final) begin
          run <= 1'b0;
        end
      end
      if (prod_tag.valid && (prod_tag.op == cns_pkg::OP_OUT24 ||
                             prod_tag.op == cns_pkg::OP_OUT25)) begin
        busy <= 1'b0;
      end
    end
  end

  // Latch the widened white sample on each input transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      w <= {white_sample, {cns_pkg::W_PAD{1'b0}}};
    end
  end

  // Apply each product to the filter state; clear the working sums per item
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < cns_pkg::NPOLE; k++) begin
        pole[k] <= '0;
      end
      delay <= '0;
      brown <= '0;
      sum   <= '0;
      tmp   <= '0;
    end else if (in_xfer) begin
      sum <= '0;
      tmp <= '0;
    end else if (prod_tag.valid) begin
      case (prod_tag.op)
        cns_pkg::OP_PIN: begin
          tmp <= r24[cns_pkg::A_W-1:0];
        end
        cns_pkg::OP_POLE: begin
          pole[prod_tag.idx] <= pole_new;
          sum <= sum + {{(cns_pkg::A_W-32){pole_new[31]}}, pole_new};
        end
        cns_pkg::OP_DIRECT: begin
          sum <= sum + r24[cns_pkg::A_W-1:0] + {{(cns_pkg::A_W-24){delay[23]}}, delay};
        end
        cns_pkg::OP_DELAY: begin
          delay <= r24[23:0];
        end
        cns_pkg::OP_PINK_OUT: begin
          tmp <= r24[cns_pkg::A_W-1:0];
        end
        cns_pkg::OP_BROWN_IN: begin
          tmp <= brown_ext + r24[cns_pkg::A_W-1:0];
        end
        cns_pkg::OP_BROWN_INV: begin
          brown <= sat32({r24[36], r24});
        end
        default: begin
        end
      endcase
    end
  end

  // Output register: load the saturated result, drop it on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (prod_tag.valid && (prod_tag.op == cns_pkg::OP_OUT24 ||
                                    prod_tag.op == cns_pkg::OP_OUT25)) begin
      out_valid <= 1'b1;
    end else if (out_xfer) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_tag.valid && (prod_tag.op == cns_pkg::OP_OUT24 ||
                           prod_tag.op == cns_pkg::OP_OUT25)) begin
      noise_sample <= sat_out(out_full);
    end
  end

`ifndef ASSERT_OFF
  // No product may be in flight while the block is idle
  a_idle_no_work: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !prod_tag.valid && !run)
    else $error("product in flight while idle");

  // A final result never lands on a full output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    prod_tag.valid && (prod_tag.op == cns_pkg::OP_OUT24 ||
                       prod_tag.op == cns_pkg::OP_OUT25) |-> !out_valid)
    else $error("result overwrites pending output");

  // Level stays clamped to unity gain
  a_level_clamp: assert property (@(posedge clk) disable iff (rst)
    level <= cns_pkg::LEVEL_MAX)
    else $error("output level above unity");
`endif

endmodule

`default_nettype wire

[tb/colored_noise_shaper_tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// colored_noise_shaper_tb - self-checking bench for the colored noise shaper
// Streams white samples through white, pink and brown shaping at several
// output levels. A bit-exact fixed-point filter model predicts every noise
// sample, and the monitor compares each output transfer in order. Both sides
// idle and stall at random, and one long receiver hold backs up the block.
// ============================================================================

module colored_noise_shaper_tb;
  import cns_pkg::*;

  localparam int     HOLD_LEN   = 400;
  localparam int     SETTLE     = 25;
  localparam int     PHASE_LEN  = 150;
  localparam longint I32_MAX    = 64'sd2147483647;
  localparam longint I32_MIN    = -64'sd2147483648;
  localparam longint NOISE_MAX  = 64'sd262143;
  localparam longint NOISE_MIN  = -64'sd262144;
  localparam longint PINK_DIR   = 64'sd8995943;
  localparam longint PINK_GAIN  = 64'sd1845494;
  localparam longint PINK_TAP   = 64'sd1944916;
  localparam longint BROWN_FEED = 64'sd335544;
  localparam longint BROWN_LEAK = 64'sd16448251;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SAMPLE_BITS-1:0] white_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [OUT_W-1:0] noise_sample;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = CFG_MODE;
  logic [LEVEL_W-1:0] cfg_data = '0;

  // Filter coefficients, Q.24
  longint pole_fb [NPOLE] = '{16758090, 16665144, 16257122, 14537458, 9227469, -12777528};
  longint pole_ff [NPOLE] = '{931436, 1259565, 2581208, 5209084, 8941454, -283501};

  // Model state and configuration
  logic [1:0] cur_mode = MODE_WHITE;
  longint     cur_level = 0;
  int         pole_acc [NPOLE] = '{default: 0};
  int         delay_tap = 0;
  int         brown_acc = 0;

  logic signed [SAMPLE_BITS-1:0] pending_white [$];
  logic signed [OUT_W-1:0]       predicted_noise [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int accepted = 0;
  int hold_at = -1;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int mismatches = 0;

  colored_noise_shaper dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .white_sample (white_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .noise_sample (noise_sample),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Q.24 product, rounded half up
  function automatic longint mul_q24(longint a, longint k);
    return (a * k + (64'sd1 <<< 23)) >>> 24;
  endfunction

  function automatic int clip32(longint x);
    if (x > I32_MAX) return int'(I32_MAX);
    if (x < I32_MIN) return int'(I32_MIN);
    return int'(x);
  endfunction

  // Advance the selected filter by one white sample and return the output
  function automatic logic signed [OUT_W-1:0] shape_white(logic signed [SAMPLE_BITS-1:0] ws);
    longint w, y, r, acc, s;
    int sh;
    int i;
    w = longint'(ws) <<< (25 - SAMPLE_BITS);
    sh = 24;
    case (cur_mode)
      MODE_PINK: begin
        acc = 0;
        for (i = 0; i < NPOLE; i++) begin
          pole_acc[i] = clip32(mul_q24(pole_acc[i], pole_fb[i]) + mul_q24(w, pole_ff[i]));
          acc += pole_acc[i];
        end
        acc += delay_tap;
        acc += mul_q24(w, PINK_DIR);
        y = mul_q24(acc, PINK_GAIN);
        delay_tap = int'(mul_q24(w, PINK_TAP));
      end
      MODE_BROWN: begin
        s = longint'(brown_acc) + mul_q24(w, BROWN_FEED);
        brown_acc = clip32(mul_q24(s, BROWN_LEAK));
        y = longint'(brown_acc) * 7;
        sh = 25;
      end
      default: y = w;
    endcase
    r = (y * cur_level + (64'sd1 <<< (sh - 1))) >>> sh;
    if (r > NOISE_MAX) r = NOISE_MAX;
    if (r < NOISE_MIN) r = NOISE_MIN;
    return r[OUT_W-1:0];
  endfunction

  // Sample driver: predict on each input transfer, then offer the next sample
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted_noise.push_back(shape_white(white_sample));
        accepted <= accepted + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pending_white.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          white_sample <= pending_white.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold, started once when the trigger count is reached
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_done && hold_at >= 0 && accepted >= hold_at) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Output monitor: check each transfer against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_noise.size() == 0) begin
          $error("noise_sample transfer with nothing predicted: got %0d", noise_sample);
          mismatches <= mismatches + 1;
        end else if (noise_sample !== predicted_noise[0]) begin
          $error("noise_sample mismatch: expected %0d, got %0d",
                 predicted_noise[0], noise_sample);
          mismatches <= mismatches + 1;
          void'(predicted_noise.pop_front());
        end else begin
          void'(predicted_noise.pop_front());
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Wait until every queued sample has gone through and its output arrived
  task automatic drain();
    while (pending_white.size() != 0 || in_valid || predicted_noise.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write one register on an idle block and track it in the model
  task automatic write_reg(logic idx, logic [LEVEL_W-1:0] data);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_MODE) begin
      if (data[1:0] != MODE_BAD) cur_mode = data[1:0];
    end else begin
      cur_level = (data > LEVEL_MAX) ? longint'(LEVEL_MAX) : longint'(data);
    end
  endtask

  // Queue random samples: uniform noise, extremes and constant runs
  task automatic queue_random(int count);
    logic signed [SAMPLE_BITS-1:0] v;
    int run;
    int sel;
    while (count > 0) begin
      sel = $urandom_range(99);
      if (sel < 60) begin
        pending_white.push_back(SAMPLE_BITS'($urandom));
        count--;
      end else if (sel < 75) begin
        case ($urandom_range(3))
          0: v = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
          1: v = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
          2: v = '0;
          default: v = '1;
        endcase
        pending_white.push_back(v);
        count--;
      end else begin
        v = $urandom_range(1) ? SAMPLE_BITS'($urandom)
                              : {$urandom_range(1) == 1, {(SAMPLE_BITS-1){1'b0}}};
        if (v == 0) v = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        run = $urandom_range(60, 10);
        while (run > 0 && count > 0) begin
          pending_white.push_back(v);
          run--;
          count--;
        end
      end
    end
  endtask

  function automatic logic [LEVEL_W-1:0] pick_level();
    case ($urandom_range(7))
      0: return '0;
      1: return LEVEL_MAX;
      2: return '1;
      3, 4, 5: return LEVEL_W'($urandom_range(LEVEL_MAX));
      default: return LEVEL_W'($urandom);
    endcase
  endfunction

  initial begin
    logic [1:0] mode_seq [4];
    logic [1:0] m;
    int pat;
    int k;
    mode_seq = '{MODE_WHITE, MODE_PINK, MODE_BROWN, MODE_BAD};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset level gives silence
    pending_white.push_back(16'sh7FFF);
    pending_white.push_back(16'sh8000);

    // Directed: white pass-through at unity level
    write_reg(CFG_LEVEL, LEVEL_MAX);
    foreach (pending_white[i]) ;
    pending_white.push_back(16'sh8000);
    pending_white.push_back(16'sh7FFF);
    pending_white.push_back(16'sh0000);
    pending_white.push_back(16'shFFFF);
    pending_white.push_back(16'sh0001);
    pending_white.push_back(16'sh5555);
    pending_white.push_back(16'shAAAA);

    // Directed: pink with an over-range level that gets clamped
    write_reg(CFG_MODE, {14'd0, MODE_PINK});
    write_reg(CFG_LEVEL, 16'hFFFF);
    pending_white.push_back(16'sh8000);
    pending_white.push_back(16'sh7FFF);
    pending_white.push_back(16'sh0000);
    repeat (4) pending_white.push_back(16'sh8000);

    // Directed: an invalid mode write leaves pink selected
    write_reg(CFG_MODE, {14'h3FFF, MODE_BAD});
    repeat (2) pending_white.push_back(16'sh7FFF);

    // Directed: brown at both rails
    write_reg(CFG_MODE, {14'd0, MODE_BROWN});
    repeat (3) pending_white.push_back(16'sh8000);
    repeat (3) pending_white.push_back(16'sh7FFF);

    // Random: three idle patterns, four settings each
    for (pat = 0; pat < 3; pat++) begin
      drain();
      case (pat)
        0: begin send_idle_pct = 36; recv_stall_pct = 74; end
        1: begin send_idle_pct = 74; recv_stall_pct = 36; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (k = 0; k < 4; k++) begin
        m = (k == 3) ? 2'($urandom_range(3)) : mode_seq[k];
        write_reg(CFG_MODE, {14'($urandom), m});
        write_reg(CFG_LEVEL, pick_level());
        if (pat == 2 && k == 1) hold_at = accepted + 40;
        queue_random(PHASE_LEN);
      end
    end

    drain();
    if (mismatches == 0 && predicted_noise.size() == 0) begin
      $display("PASS colored_noise_shaper");
    end else begin
      $display("FAIL colored_noise_shaper");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("FAIL colored_noise_shaper");
    $finish;
  end

endmodule
